// ===== hw/rtl/acc_pkg.sv =====
// Shared types, constants and character classing functions for the alignment
// column conservation unit. Used by every module in hw/rtl; no dependencies.
`default_nettype none

package acc_pkg;

    localparam int COLS        = 2048;
    localparam int COL_W       = 11;
    localparam int POS_W       = 12;
    localparam int COUNT_BITS  = 16;
    localparam int CLASS_SLOTS = 52;
    localparam int SLOT_W      = $clog2(CLASS_SLOTS);
    localparam int MEM_DEPTH   = COLS * CLASS_SLOTS;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int ALU_W       = 24;
    localparam int PROD_W      = 23;
    localparam int HOM_W       = 15;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int ENTRY_W     = 6;

    localparam logic [HOM_W-1:0]      HOM_FULL   = 15'd25600;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [ENTRY_W-1:0]    ENTRY_LAST = 6'd39;
    localparam logic [7:0]            DOT_CHAR   = 8'h2E;
    localparam logic [7:0]            GAP_CHAR   = 8'h2D;

    localparam logic [7:0] NUC_REAL [5] = '{"A", "C", "G", "T", "U"};
    localparam logic [7:0] NUC_REST [12] =
        '{"M", "R", "W", "S", "Y", "K", "V", "H", "D", "B", "X", "N"};
    localparam logic [7:0] PROT_REAL [22] =
        '{"A", "B", "C", "D", "E", "F", "G", "H", "I", "K", "L",
          "M", "N", "P", "Q", "R", "S", "T", "V", "W", "Y", "Z"};

    typedef enum logic [1:0] {
        CMD_CHAR  = 2'd0,
        CMD_END   = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_RSVD  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_ALPHABET = 3'd0,
        CFG_START    = 3'd1,
        CFG_STOP     = 3'd2,
        CFG_MIN_HOM  = 3'd3,
        CFG_MAX_HOM  = 3'd4,
        CFG_DOT      = 3'd5,
        CFG_GAP      = 3'd6,
        CFG_AMBIG    = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_WR,
        Q_RD, Q_EV, Q_ACC, Q_DEN, Q_SAT, Q_MB,
        Q_MMIN, Q_CMIN, Q_MMAX, Q_CMAX, Q_DIV, Q_FIN
    } t_state;

    typedef enum logic [1:0] {
        E_STOP, E_UNC, E_CAND
    } t_ekind;

    typedef enum logic {
        ALU_ADD, ALU_SUB
    } t_alu_op;

    typedef struct packed {
        logic        prot;
        logic [11:0] start_col;
        logic [11:0] stop_col;
        logic [6:0]  min_hom;
        logic [6:0]  max_hom;
        logic [1:0]  dot_mode;
        logic [1:0]  gap_mode;
        logic [4:0]  ambig_lower_modes;
    } t_cfg;

    typedef struct packed {
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             ge;
    } t_alu_rsp;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic             valid;
        logic [HOM_W-1:0] homology;
        logic             keep;
    } t_res;

    typedef struct packed {
        logic              use_it;
        logic [SLOT_W-1:0] slot;
    } t_map;

    typedef struct packed {
        logic              en;
        logic              flag;
        t_ekind            kind;
        logic [SLOT_W-1:0] slot;
    } t_entry;

    typedef struct packed {
        logic [2:0] amb;
        logic [2:0] low;
    } t_modes;

    // Splits the combined register into ambiguity and lowercase modes.
    function automatic t_modes decode_modes(input logic [4:0] v);
        t_modes     m;
        logic [2:0] q;
        if (v >= 5'd30)      q = 3'd6;
        else if (v >= 5'd25) q = 3'd5;
        else if (v >= 5'd20) q = 3'd4;
        else if (v >= 5'd15) q = 3'd3;
        else if (v >= 5'd10) q = 3'd2;
        else if (v >= 5'd5)  q = 3'd1;
        else                 q = 3'd0;
        m.amb = 3'(v - 5'(q * 3'd5));
        m.low = (q > 3'd4) ? 3'd0 : q;
        return m;
    endfunction

    function automatic logic [SLOT_W-1:0] stop_slot(input t_cfg cfg);
        return cfg.prot ? 6'd48 : 6'd36;
    endfunction

    // Class slot of one character byte under the current modes.
    function automatic t_map map_char(input logic [7:0] c, input t_cfg cfg);
        t_map              m;
        t_modes            md;
        logic              low_c, rf, sf;
        logic [7:0]        u;
        logic [4:0]        ri;
        logic [3:0]        si;
        logic [SLOT_W-1:0] nr, ns, n, xs, up_slot, rest_up, base;
        md    = decode_modes(cfg.ambig_lower_modes);
        low_c = (c >= "a") && (c <= "z");
        u     = low_c ? 8'(c - 8'd32) : c;
        nr    = cfg.prot ? 6'd22 : 6'd5;
        ns    = cfg.prot ? 6'd1 : 6'd12;
        n     = stop_slot(cfg);
        rf    = 1'b0;
        sf    = 1'b0;
        ri    = '0;
        si    = '0;
        for (int i = 0; i < 5; i++) begin
            if (!cfg.prot && u == NUC_REAL[i]) begin
                rf = 1'b1;
                ri = 5'(i);
            end
        end
        for (int i = 0; i < 22; i++) begin
            if (cfg.prot && u == PROT_REAL[i]) begin
                rf = 1'b1;
                ri = 5'(i);
            end
        end
        for (int i = 0; i < 12; i++) begin
            if (!cfg.prot && u == NUC_REST[i]) begin
                sf = 1'b1;
                si = 4'(i);
            end
        end
        if (cfg.prot && u == "X") begin
            sf = 1'b1;
        end
        // U folds onto T and N onto X for nucleotides.
        up_slot = (!cfg.prot && ri == 5'd4) ? 6'd3 : 6'(ri);
        rest_up = 6'(2 * nr) + ((!cfg.prot && si == 4'd11) ? 6'd10 : 6'(si));
        xs      = 6'(2 * nr) + (cfg.prot ? 6'd0 : 6'd10);
        m.use_it = 1'b0;
        m.slot   = n;
        if (c == DOT_CHAR) begin
            m.use_it = (cfg.dot_mode != 2'd0);
            m.slot   = (cfg.dot_mode == 2'd2) ? n : 6'(2 * nr + 2 * ns);
        end else if (c == GAP_CHAR) begin
            m.use_it = (cfg.gap_mode != 2'd0);
            m.slot   = (cfg.gap_mode == 2'd2) ? n : 6'(2 * nr + 2 * ns + 1);
        end else if (rf) begin
            m.use_it = 1'b1;
            if (!low_c) begin
                m.slot = up_slot;
            end else begin
                base = nr + up_slot;
                priority case (md.low)
                    3'd0: m.use_it = 1'b0;
                    3'd1: m.slot = nr;
                    3'd2: m.slot = n;
                    3'd4: m.slot = up_slot;
                    default: m.slot = base;
                endcase
                if (md.low == 3'd0) m.slot = base;
            end
        end else if (sf) begin
            m.use_it = (md.amb != 3'd0);
            if (!low_c) base = rest_up;
            else        base = rest_up + ns;
            if (md.amb == 3'd1)                  m.slot = xs;
            else if (md.amb == 3'd2)             m.slot = n;
            else if (low_c && md.low == 3'd4)    m.slot = rest_up;
            else                                 m.slot = base;
        end
        return m;
    endfunction

    // One entry of the query walk: stopper, uncounted, then the candidates.
    function automatic t_entry query_entry(input logic [ENTRY_W-1:0] p, input t_cfg cfg);
        t_entry             e;
        t_modes             md;
        logic [ENTRY_W-1:0] k;
        logic [7:0]         ch;
        logic [3:0]         j;
        md     = decode_modes(cfg.ambig_lower_modes);
        k      = p - 6'd2;
        j      = 4'(k - 6'd25);
        ch     = 8'h00;
        e.en   = 1'b0;
        e.flag = 1'b0;
        e.kind = E_CAND;
        e.slot = stop_slot(cfg);
        if (p == 6'd0) begin
            e.en   = 1'b1;
            e.kind = E_STOP;
        end else if (p == 6'd1) begin
            e.en   = 1'b1;
            e.kind = E_UNC;
            e.slot = stop_slot(cfg) + 6'd1;
        end else begin
            if (k < 6'd22) begin
                e.en = cfg.prot || (k < 6'd5);
                if (cfg.prot)      ch = PROT_REAL[k[4:0]];
                else if (k < 6'd5) ch = NUC_REAL[k[2:0]];
            end else if (k == 6'd22) begin
                ch     = DOT_CHAR;
                e.en   = (cfg.dot_mode == 2'd1);
                e.flag = 1'b1;
            end else if (k == 6'd23) begin
                ch     = GAP_CHAR;
                e.en   = (cfg.gap_mode == 2'd1);
                e.flag = 1'b1;
            end else if (k == 6'd24) begin
                ch     = "X";
                e.en   = (md.amb == 3'd1);
                e.flag = 1'b1;
            end else if (k < 6'd37) begin
                e.en = (md.amb == 3'd4) && (!cfg.prot || k == 6'd25);
                if (cfg.prot)        ch = "X";
                else if (j < 4'd12)  ch = NUC_REST[j];
            end else if (k == 6'd37) begin
                ch     = "a";
                e.en   = (md.low == 3'd1);
                e.flag = 1'b1;
            end
            e.slot = map_char(ch, cfg).slot;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/acc_alu.sv =====
// Shared add/subtract unit of the conservation unit; the count and sequence
// increments and every query sum, compare and divide step go through it. Depends on acc_pkg.
`default_nettype none

module acc_alu (
    input  var acc_pkg::t_alu_req i_req,
    output var acc_pkg::t_alu_rsp o_rsp
);
    import acc_pkg::*;

    logic [ALU_W:0] full;

    always_comb begin
        unique case (i_req.op)
            ALU_ADD: full = {1'b0, i_req.a} + {1'b0, i_req.b};
            ALU_SUB: full = {1'b0, i_req.a} + {1'b0, ~i_req.b} + (ALU_W + 1)'(1);
        endcase
        o_rsp.sum = full[ALU_W-1:0];
        // For a subtraction the carry out means a >= b.
        o_rsp.ge  = full[ALU_W];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/acc_core.sv =====
// Sequencer, counter memory and query datapath of the conservation unit.
// Depends on acc_pkg and acc_alu.
`default_nettype none

module acc_core (
    input  var logic                        i_clk,
    input  var logic                        i_rst_n,
    input  var acc_pkg::t_cfg               i_cfg,
    input  var logic                        i_in_valid,
    output var logic                        o_in_stall,
    input  var logic [1:0]                  i_cmd,
    input  var logic [7:0]                  i_char_code,
    input  var logic [acc_pkg::COL_W-1:0]   i_column,
    input  var logic                        i_res_ready,
    output var logic                        o_res_push,
    output var acc_pkg::t_res               o_res
);
    import acc_pkg::*;

    t_state r_state, n_state;

    logic [COUNT_BITS-1:0] mem [MEM_DEPTH];
    logic [COUNT_BITS-1:0] r_rdata;
    logic                  mem_we, mem_re;
    logic [ADDR_W-1:0]     mem_wa, mem_ra;
    logic [COUNT_BITS-1:0] mem_wd;

    logic [ADDR_W-1:0]     r_clr, r_wa, r_base;
    logic [POS_W-1:0]      r_pos;
    logic [COUNT_BITS-1:0] r_seq, r_best, r_den, r_rem;
    logic [COL_W-1:0]      r_col;
    logic [ENTRY_W-1:0]    r_p;
    logic                  r_bflag, r_stop_seen, r_sat, r_keep, r_valid;
    logic [ALU_W-1:0]      r_unc;
    logic [PROD_W-1:0]     r_b100, r_prod;
    logic [HOM_W-1:0]      r_dv, r_hom;
    logic [3:0]            r_cnt;

    t_alu_req          alu_req;
    t_alu_rsp          alu_rsp;
    t_entry            ent;
    t_map              cmap;
    logic              accept, cnt_ok, col_ok, inv;
    logic [SLOT_W-1:0] cnt_slot;
    logic [ADDR_W-1:0] cnt_addr;
    logic [COUNT_BITS:0] trial;
    logic [15:0]       mul_a;
    logic [6:0]        mul_b;
    logic [PROD_W-1:0] mul_p;

    acc_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    assign cnt_ok = (r_pos >= i_cfg.start_col) && (r_pos < i_cfg.stop_col)
                    && (r_pos < POS_W'(COLS));
    assign col_ok = ({1'b0, i_column} < POS_W'(COLS)) && ({1'b0, i_column} >= i_cfg.start_col)
                    && ({1'b0, i_column} < i_cfg.stop_col);
    assign cmap     = map_char(i_char_code, i_cfg);
    assign cnt_slot = cmap.use_it ? cmap.slot : stop_slot(i_cfg) + SLOT_W'(1);
    assign cnt_addr = ADDR_W'(r_pos[COL_W-1:0]) * ADDR_W'(CLASS_SLOTS) + ADDR_W'(cnt_slot);
    assign ent      = query_entry(r_p, i_cfg);
    assign trial    = {r_rem, r_dv[HOM_W-1]};
    assign inv      = r_stop_seen || (r_best == '0) || r_bflag || !alu_rsp.ge
                      || (alu_rsp.sum == '0);
    assign mul_p    = PROD_W'(mul_a * mul_b);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (r_clr == ADDR_W'(MEM_DEPTH - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_CHAR:  if (cnt_ok) n_state = S_WR;
                        CMD_QUERY: n_state = col_ok ? Q_RD : Q_FIN;
                        CMD_END, CMD_RSVD: n_state = S_IDLE;
                    endcase
                end
            end
            S_WR:   n_state = S_IDLE;
            Q_RD: begin
                if (ent.en)                  n_state = Q_EV;
                else if (r_p == ENTRY_LAST)  n_state = Q_DEN;
            end
            Q_EV: begin
                if (ent.kind == E_CAND && ent.flag) n_state = Q_ACC;
                else if (r_p == ENTRY_LAST)         n_state = Q_DEN;
                else                                n_state = Q_RD;
            end
            Q_ACC:  n_state = (r_p == ENTRY_LAST) ? Q_DEN : Q_RD;
            Q_DEN:  n_state = inv ? Q_FIN : Q_SAT;
            Q_SAT:  n_state = Q_MB;
            Q_MB:   n_state = Q_MMIN;
            Q_MMIN: n_state = Q_CMIN;
            Q_CMIN: n_state = Q_MMAX;
            Q_MMAX: n_state = Q_CMAX;
            Q_CMAX: n_state = r_sat ? Q_FIN : Q_DIV;
            Q_DIV:  if (r_cnt == 4'd14) n_state = Q_FIN;
            Q_FIN:  if (i_res_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Memory, shared unit and multiplier control.
    always_comb begin
        mem_we  = 1'b0;
        mem_re  = 1'b0;
        mem_wa  = r_wa;
        mem_ra  = cnt_addr;
        mem_wd  = alu_rsp.sum[COUNT_BITS-1:0];
        alu_req = '{op: ALU_ADD, a: '0, b: '0};
        mul_a   = r_den;
        mul_b   = i_cfg.min_hom;
        o_res_push = 1'b0;
        unique case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = '0;
            end
            S_IDLE: begin
                mem_re  = accept && (t_cmd'(i_cmd) == CMD_CHAR) && cnt_ok;
                alu_req = '{op: ALU_ADD, a: ALU_W'(r_seq), b: ALU_W'(1)};
            end
            S_WR: begin
                mem_we  = (r_rdata != COUNT_MAX);
                alu_req = '{op: ALU_ADD, a: ALU_W'(r_rdata), b: ALU_W'(1)};
            end
            Q_RD: begin
                mem_re = ent.en;
                mem_ra = r_base + ADDR_W'(ent.slot);
            end
            Q_EV:   alu_req = '{op: ALU_SUB, a: ALU_W'(r_best), b: ALU_W'(r_rdata)};
            Q_ACC:  alu_req = '{op: ALU_ADD, a: r_unc, b: ALU_W'(r_rdata)};
            Q_DEN:  alu_req = '{op: ALU_SUB, a: ALU_W'(r_seq), b: r_unc};
            Q_SAT:  alu_req = '{op: ALU_SUB, a: ALU_W'(r_den), b: ALU_W'(r_best)};
            Q_MB: begin
                mul_a = r_best;
                mul_b = 7'd100;
            end
            Q_MMIN: mul_b = i_cfg.min_hom;
            Q_CMIN: alu_req = '{op: ALU_SUB, a: ALU_W'(r_b100), b: ALU_W'(r_prod)};
            Q_MMAX: mul_b = i_cfg.max_hom;
            Q_CMAX: alu_req = '{op: ALU_SUB, a: ALU_W'(r_prod), b: ALU_W'(r_b100)};
            Q_DIV:  alu_req = '{op: ALU_SUB, a: ALU_W'(trial), b: ALU_W'(r_den)};
            Q_FIN:  o_res_push = i_res_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (mem_re) r_rdata <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_pos   <= '0;
            r_seq   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) r_clr <= r_clr + ADDR_W'(1);
            if (accept) begin
                unique case (t_cmd'(i_cmd))
                    CMD_CHAR: if (r_pos < POS_W'(COLS)) r_pos <= r_pos + POS_W'(1);
                    CMD_END: begin
                        r_pos <= '0;
                        if (r_seq != COUNT_MAX) r_seq <= alu_rsp.sum[COUNT_BITS-1:0];
                    end
                    CMD_QUERY, CMD_RSVD: ;
                endcase
            end
        end
    end

    // Query datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_wa        <= cnt_addr;
                r_col       <= i_column;
                r_base      <= ADDR_W'(i_column) * ADDR_W'(CLASS_SLOTS);
                r_p         <= '0;
                r_best      <= '0;
                r_bflag     <= 1'b0;
                r_stop_seen <= 1'b0;
                r_unc       <= '0;
                r_valid     <= 1'b0;
                r_keep      <= 1'b0;
            end
            Q_RD: if (!ent.en) r_p <= r_p + ENTRY_W'(1);
            Q_EV: begin
                unique case (ent.kind)
                    E_STOP: r_stop_seen <= (r_rdata != '0);
                    E_UNC:  r_unc <= ALU_W'(r_rdata);
                    E_CAND: begin
                        if (!alu_rsp.ge) begin
                            r_best  <= r_rdata;
                            r_bflag <= ent.flag;
                        end
                    end
                    default: ;
                endcase
                if (!(ent.kind == E_CAND && ent.flag)) r_p <= r_p + ENTRY_W'(1);
            end
            Q_ACC: begin
                r_unc <= alu_rsp.sum;
                r_p   <= r_p + ENTRY_W'(1);
            end
            Q_DEN: begin
                r_valid <= !inv;
                r_den   <= alu_rsp.sum[COUNT_BITS-1:0];
            end
            Q_SAT:  r_sat  <= !alu_rsp.ge;
            Q_MB:   r_b100 <= mul_p;
            Q_MMIN: r_prod <= mul_p;
            Q_CMIN: r_keep <= alu_rsp.ge;
            Q_MMAX: r_prod <= mul_p;
            Q_CMAX: begin
                r_keep <= r_keep && alu_rsp.ge;
                r_rem  <= r_b100[PROD_W-1:7];
                r_dv   <= {r_b100[6:0], 8'd0};
                r_hom  <= r_sat ? HOM_FULL : '0;
                r_cnt  <= '0;
            end
            Q_DIV: begin
                r_rem <= alu_rsp.ge ? alu_rsp.sum[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
                r_dv  <= {r_dv[HOM_W-2:0], 1'b0};
                r_hom <= {r_hom[HOM_W-2:0], alu_rsp.ge};
                r_cnt <= r_cnt + 4'd1;
            end
            default: ;
        endcase
    end

    assign o_res.column   = r_col;
    assign o_res.valid    = r_valid;
    assign o_res.homology = r_valid ? r_hom : '0;
    assign o_res.keep     = r_valid && r_keep;

endmodule

`default_nettype wire

// ===== hw/rtl/alignment_column_conservation_unit.sv =====
// Top level of the alignment column conservation unit: configuration
// registers, result register and the core. Depends on acc_pkg and acc_core.
//
// Requests arrive on the input channel (i_in_valid / o_in_stall) as a command
// with a character byte or a column. A character request bumps one class
// counter of the current column, an end request closes a sequence, and a
// query request produces one result on the output channel (o_out_valid /
// i_out_stall). Configuration is written through i_cfg_we / i_cfg_idx /
// i_cfg_data while the block is idle; the user is bound to this, and the
// block itself does not enforce it. A character request reads the old count
// from the counter memory and then writes the incremented one. A query
// walks up to 40 counter slots, reading each slot that the current modes
// enable, with an extra accumulate step for a flagged candidate, then runs
// the compares and a 15-step divider.
// After reset the counter memory is cleared one entry a cycle while o_in_stall
// stays high; configuration writes are taken meanwhile.
// A finished result waits in the output register while the receiver stalls;
// the block keeps taking character and end requests, and a further query
// holds its result until the register is free.
`default_nettype none

module alignment_column_conservation_unit (
    input  var logic                                i_clk,
    input  var logic                                i_rst_n,
    input  var logic                                i_in_valid,
    output var logic                                o_in_stall,
    input  var logic [1:0]                          i_cmd,
    input  var logic [7:0]                          i_char_code,
    input  var logic [acc_pkg::COL_W-1:0]           i_column,
    output var logic                                o_out_valid,
    input  var logic                                i_out_stall,
    output var logic [acc_pkg::COL_W-1:0]           o_out_column,
    output var logic                                o_column_valid,
    output var logic [acc_pkg::HOM_W-1:0]           o_homology,
    output var logic                                o_keep,
    input  var logic                                i_cfg_we,
    input  var logic [acc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  var logic [acc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import acc_pkg::*;

    t_cfg r_cfg;
    t_res r_res, core_res;
    logic r_ov;
    logic res_ready, res_push;

    // Configuration registers; each write takes the low bits of the data word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prot              <= 1'b0;
            r_cfg.start_col         <= 12'd0;
            r_cfg.stop_col          <= 12'd2048;
            r_cfg.min_hom           <= 7'd0;
            r_cfg.max_hom           <= 7'd100;
            r_cfg.dot_mode          <= 2'd0;
            r_cfg.gap_mode          <= 2'd0;
            r_cfg.ambig_lower_modes <= 5'd0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ALPHABET: r_cfg.prot              <= i_cfg_data[0];
                CFG_START:    r_cfg.start_col         <= i_cfg_data;
                CFG_STOP:     r_cfg.stop_col          <= i_cfg_data;
                CFG_MIN_HOM:  r_cfg.min_hom           <= i_cfg_data[6:0];
                CFG_MAX_HOM:  r_cfg.max_hom           <= i_cfg_data[6:0];
                CFG_DOT:      r_cfg.dot_mode          <= i_cfg_data[1:0];
                CFG_GAP:      r_cfg.gap_mode          <= i_cfg_data[1:0];
                CFG_AMBIG:    r_cfg.ambig_lower_modes <= i_cfg_data[4:0];
            endcase
        end
    end

    // The result register is free when empty or when its result leaves now.
    assign res_ready = !r_ov || !i_out_stall;

    acc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_char_code (i_char_code),
        .i_column    (i_column),
        .i_res_ready (res_ready),
        .o_res_push  (res_push),
        .o_res       (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (res_push) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) r_res <= core_res;
    end

    assign o_out_valid    = r_ov;
    assign o_out_column   = r_res.column;
    assign o_column_valid = r_res.valid;
    assign o_homology     = r_res.homology;
    assign o_keep         = r_res.keep;

    // A waiting result must not be overwritten while the receiver stalls.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && i_out_stall |=> r_ov && $stable(r_res))
        else $error("result register changed while stalled");

    // Homology never exceeds one hundred percent.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_homology <= HOM_FULL)
        else $error("homology out of range");

    // A kept column is always a valid one, and a rejected one reads zero.
    a_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_column_valid |-> !o_keep && o_homology == '0)
        else $error("rejected column carries homology or keep");

    // A result is only pushed when the result register is free.
    a_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !r_ov || !i_out_stall)
        else $error("result pushed into a full register");

endmodule

`default_nettype wire
